>>> design/mfic_pkg.sv
// ----------------------------------------------------------------------------
// mfic_pkg
// shared types and codes of the interpolated-coefficient mimo fir unit
// ----------------------------------------------------------------------------
package mfic_pkg;

  // widths fixed by the item format
  localparam int MAX_BANDS = 4;
  localparam int SMP_W     = 16;
  localparam int CMD_W     = 2;
  localparam int APB_AW    = 3;

  // command codes carried in tuser
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SLOPE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // register word index (paddr bit 2)
  localparam logic REG_BLEND = 1'b0;

  // per-cycle control travelling with one multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mfic_ctl_t;

  // coefficient store write strobes
  typedef struct packed {
    logic we_base;
    logic we_slope;
  } mfic_cwr_t;

endpackage

>>> design/mfic_lane.sv
// ----------------------------------------------------------------------------
// mfic_lane
// one output band: coefficient stores, weight blend and mac pipeline
// ----------------------------------------------------------------------------
module mfic_lane #(
  parameter int BANDS = 4,
  parameter int TAPS  = 65
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [15:0]            blend_i,
  input  mfic_pkg::mfic_cwr_t           cwr_i,
  input  logic [$clog2(BANDS*TAPS)-1:0] wr_addr_i,
  input  logic signed [15:0]            wr_data_i,
  input  logic [$clog2(BANDS*TAPS)-1:0] rd_addr_i,
  input  mfic_pkg::mfic_ctl_t           ctl_i,
  input  logic signed [15:0]            smp_i,
  output logic signed [15:0]            res_o,
  output logic                          res_ok_o
);

  localparam int COEF_D = BANDS * TAPS;
  localparam int ACC_W  = 34 + $clog2(COEF_D) + 1;

  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(8192);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  logic signed [15:0] base_mem  [COEF_D];
  logic signed [15:0] slope_mem [COEF_D];

  logic signed [15:0] base_rd_q, slope_rd_q;
  logic signed [31:0] prod1_d, prod1_q;
  logic signed [15:0] base2_q, smp2_q, smp3_q;
  logic signed [32:0] rsum1;
  logic signed [17:0] w3_d, w3_q;
  logic signed [33:0] prod2_q;
  logic signed [ACC_W-1:0] acc_d, acc_q, rsum2, rsh;
  logic signed [15:0] res_d, res_q;
  logic res_ok_q;

  mfic_pkg::mfic_ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;

  // coefficient stores, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cwr_i.we_base) begin
      base_mem[wr_addr_i] <= wr_data_i;
    end
    if (cwr_i.we_slope) begin
      slope_mem[wr_addr_i] <= wr_data_i;
    end
    base_rd_q  <= base_mem[rd_addr_i];
    slope_rd_q <= slope_mem[rd_addr_i];
  end

  // blend product, then rounded weight, then weight times sample
  assign prod1_d = blend_i * slope_rd_q;
  assign rsum1   = 33'(prod1_q) + 33'sd8192;
  assign w3_d    = 18'(base2_q) + signed'(rsum1[31:14]);

  // accumulate, first step restarts the sum
  assign acc_d = ctl4_q.first ? ACC_W'(prod2_q) : acc_q + ACC_W'(prod2_q);

  // round half up and saturate to q1.15
  assign rsum2 = acc_q + RND;
  assign rsh   = rsum2 >>> 14;

  always_comb begin
    if (rsh > SAT_HI) begin
      res_d = 16'sh7fff;
    end else if (rsh < SAT_LO) begin
      res_d = -16'sh8000;
    end else begin
      res_d = rsh[15:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod1_q <= prod1_d;
    base2_q <= base_rd_q;
    smp2_q  <= smp_i;
    w3_q    <= w3_d;
    smp3_q  <= smp2_q;
    prod2_q <= w3_q * smp3_q;
    if (ctl4_q.valid) begin
      acc_q <= acc_d;
    end
    if (ctl5_q.valid && ctl5_q.last) begin
      res_q <= res_d;
    end
  end

  // control pipeline and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q   <= '0;
      ctl2_q   <= '0;
      ctl3_q   <= '0;
      ctl4_q   <= '0;
      ctl5_q   <= '0;
      res_ok_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      if (ctl_i.valid && ctl_i.first) begin
        res_ok_q <= 1'b0;
      end else if (ctl5_q.valid && ctl5_q.last) begin
        res_ok_q <= 1'b1;
      end
    end
  end

  assign res_o    = res_q;
  assign res_ok_o = res_ok_q;

endmodule

>>> design/mfic_seq.sv
// ----------------------------------------------------------------------------
// mfic_seq
// step sequencer and shared sample history for all lanes
// ----------------------------------------------------------------------------
module mfic_seq #(
  parameter int BANDS = 4,
  parameter int TAPS  = 65
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          clear_i,
  input  logic signed [15:0]            smp_i [mfic_pkg::MAX_BANDS],
  input  logic                          res_ok_i,
  input  logic                          out_free_i,
  output logic                          ready_o,
  output mfic_pkg::mfic_ctl_t           ctl_o,
  output logic [$clog2(BANDS*TAPS)-1:0] coef_addr_o,
  output logic signed [15:0]            smp_o,
  output logic                          load_o
);

  localparam int COEF_D  = BANDS * TAPS;
  localparam int COEF_AW = $clog2(COEF_D);
  localparam int HIST    = TAPS - 1;
  localparam int HIST_W  = (HIST > 1) ? $clog2(HIST) : 1;
  localparam int HD      = BANDS * HIST;
  localparam int HA_W    = (HD > 1) ? $clog2(HD) : 1;
  localparam int K_W     = $clog2(TAPS);
  localparam int BW      = (BANDS > 1) ? $clog2(BANDS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WRBK = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [K_W-1:0]     k_q, k_d, fill_q, fill_d;
  logic [BW-1:0]      p_q, p_d, p1_q;
  logic [COEF_AW-1:0] c_q, c_d;
  logic [HA_W-1:0]    pb_q, pb_d;
  logic [HIST_W-1:0]  rp_q, rp_d, hd_q, hd_d, hd_nx;
  logic               newest1_q, live1_q;
  logic               load;

  logic signed [15:0] hist_mem [HD];
  logic signed [15:0] hist_rd_q;
  logic signed [15:0] smp_q [BANDS];

  assign hd_nx = (hd_q == HIST_W'(HIST - 1)) ? '0 : hd_q + 1'b1;

  // sequencer: run over bands and taps, write back history, hand over result
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    p_d     = p_q;
    c_d     = c_q;
    pb_d    = pb_q;
    rp_d    = rp_q;
    hd_d    = hd_q;
    fill_d  = fill_q;
    load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          k_d     = '0;
          p_d     = '0;
          c_d     = '0;
          pb_d    = '0;
          rp_d    = hd_q;
        end else if (clear_i) begin
          fill_d = '0;
        end
      end
      ST_RUN: begin
        c_d = c_q + 1'b1;
        if (k_q == K_W'(TAPS - 1)) begin
          k_d  = '0;
          p_d  = p_q + 1'b1;
          pb_d = pb_q + HA_W'(HIST);
          rp_d = hd_q;
        end else begin
          k_d = k_q + 1'b1;
          if (k_q != '0) begin
            rp_d = (rp_q == '0) ? HIST_W'(HIST - 1) : rp_q - 1'b1;
          end
        end
        if (c_q == COEF_AW'(COEF_D - 1)) begin
          state_d = ST_WRBK;
          p_d     = '0;
          pb_d    = '0;
        end
      end
      ST_WRBK: begin
        p_d  = p_q + 1'b1;
        pb_d = pb_q + HA_W'(HIST);
        if (p_q == BW'(BANDS - 1)) begin
          state_d = ST_WAIT;
          hd_d    = hd_nx;
          if (fill_q != K_W'(HIST)) begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (res_ok_i && out_free_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      p_q       <= '0;
      c_q       <= '0;
      pb_q      <= '0;
      rp_q      <= '0;
      hd_q      <= '0;
      fill_q    <= '0;
      newest1_q <= 1'b0;
      live1_q   <= 1'b0;
      p1_q      <= '0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      p_q       <= p_d;
      c_q       <= c_d;
      pb_q      <= pb_d;
      rp_q      <= rp_d;
      hd_q      <= hd_d;
      fill_q    <= fill_d;
      newest1_q <= (k_q == '0);
      live1_q   <= (k_q <= fill_q);
      p1_q      <= p_q;
    end
  end

  // history ring per band, read while running, written back after
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRBK) begin
      hist_mem[pb_q + HA_W'(hd_nx)] <= smp_q[p_q];
    end
    hist_rd_q <= hist_mem[pb_q + HA_W'(rp_q)];
  end

  // newest samples of the item being filtered
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      for (int b = 0; b < BANDS; b++) begin
        smp_q[b] <= smp_i[b];
      end
    end
  end

  // sample for the step issued in the previous cycle
  always_comb begin
    if (newest1_q) begin
      smp_o = smp_q[p1_q];
    end else if (live1_q) begin
      smp_o = hist_rd_q;
    end else begin
      smp_o = '0;
    end
  end

  assign ctl_o.valid = (state_q == ST_RUN);
  assign ctl_o.first = (c_q == '0);
  assign ctl_o.last  = (c_q == COEF_AW'(COEF_D - 1));
  assign coef_addr_o = c_q;
  assign ready_o     = (state_q == ST_IDLE);
  assign load_o      = load;

endmodule

>>> design/mfic_merge.sv
// ----------------------------------------------------------------------------
// mfic_merge
// gathers the lane results into one output item and holds it for the sink
// ----------------------------------------------------------------------------
module mfic_merge #(
  parameter int BANDS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic signed [15:0] res_i [BANDS],
  input  logic               tready_i,
  output logic               tvalid_o,
  output logic [63:0]        tdata_o,
  output logic               free_o
);

  logic        valid_q;
  logic [63:0] data_q, data_d;

  // unused bands read as zero
  always_comb begin
    data_d = '0;
    for (int b = 0; b < BANDS; b++) begin
      data_d[16*b +: 16] = res_i[b];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = data_q;
  assign free_o   = !valid_q || tready_i;

endmodule

>>> design/mimo_fir_interpolated_coeffs_unit.sv
// ----------------------------------------------------------------------------
// mimo_fir_interpolated_coeffs_unit
// all-to-all multi-band fir with blended base and slope coefficients
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis stream; tuser carries the command (push,
// base coefficient write, slope coefficient write, clear history). Only a
// push gives an output item on m_axis, one q1.15 result per band.
// Coefficient writes and clear history leave the input ready for the next item.
// A push runs BANDS*TAPS steps, one per cycle, with one lane per output band
// working in parallel; the step count over input bands and taps sets the
// rate. The history write-back overlaps the pipeline drain, and the result
// is offered once the lanes hold it and the output register is free. A new
// item is taken once the result has moved into the output register.
// If the sink stalls, the result waits in the output register; the unit
// still takes items, but after the next push it holds s_axis_tready low
// until the output register is free.
// Reset clears the history (through its fill count), the blend factor and
// the handshakes. Coefficients are undefined until written and must all be
// loaded before the first push. blend_factor is written over the apb port.
// ----------------------------------------------------------------------------
module mimo_fir_interpolated_coeffs_unit #(
  parameter int BANDS = 4,
  parameter int TAPS  = 65
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfic_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: coef_out_band, coef_in_band, coef_tap, coef_value,
  //        sample_0, sample_1, sample_2, sample_3, zero fill
  input  logic [95:0]                   s_axis_tdata,
  // tuser: command
  input  logic [1:0]                    s_axis_tuser,
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: out_0, out_1, out_2, out_3
  output logic [63:0]                   m_axis_tdata
);

  localparam int COEF_AW = $clog2(BANDS * TAPS);

  logic signed [15:0] blend_q;
  logic               accept, start, clear, in_range, ready;
  logic [1:0]         ob, ib;
  logic [6:0]         tap;
  logic signed [15:0] cval;
  logic signed [15:0] smp [mfic_pkg::MAX_BANDS];
  logic [COEF_AW-1:0] wr_addr, coef_addr;
  logic signed [15:0] lane_smp;
  logic signed [15:0] res [BANDS];
  logic               res_ok [BANDS];
  logic               load, out_free;

  mfic_pkg::mfic_cwr_t cwr;
  mfic_pkg::mfic_ctl_t ctl;

  // blend factor register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == mfic_pkg::REG_BLEND) begin
      blend_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == mfic_pkg::REG_BLEND) ? {16'h0000, blend_q} : '0;

  // item fields
  assign ob   = s_axis_tdata[1:0];
  assign ib   = s_axis_tdata[3:2];
  assign tap  = s_axis_tdata[10:4];
  assign cval = s_axis_tdata[26:11];
  assign smp[0] = s_axis_tdata[42:27];
  assign smp[1] = s_axis_tdata[58:43];
  assign smp[2] = s_axis_tdata[74:59];
  assign smp[3] = s_axis_tdata[90:75];

  // command decode
  assign accept   = s_axis_tvalid && ready;
  assign start    = accept && s_axis_tuser == mfic_pkg::CMD_PUSH;
  assign clear    = accept && s_axis_tuser == mfic_pkg::CMD_CLEAR;
  assign in_range = ({1'b0, ob} < 3'(BANDS)) && ({1'b0, ib} < 3'(BANDS))
                 && ({1'b0, tap} < 8'(TAPS));
  assign cwr.we_base  = accept && in_range && s_axis_tuser == mfic_pkg::CMD_BASE;
  assign cwr.we_slope = accept && in_range && s_axis_tuser == mfic_pkg::CMD_SLOPE;
  assign wr_addr = COEF_AW'(32'(ib) * TAPS + 32'(tap));

  assign s_axis_tready = ready;

  mfic_seq #(
    .BANDS (BANDS),
    .TAPS  (TAPS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .clear_i     (clear),
    .smp_i       (smp),
    .res_ok_i    (res_ok[0]),
    .out_free_i  (out_free),
    .ready_o     (ready),
    .ctl_o       (ctl),
    .coef_addr_o (coef_addr),
    .smp_o       (lane_smp),
    .load_o      (load)
  );

  // one lane per output band
  for (genvar l = 0; l < BANDS; l++) begin : g_lane
    mfic_pkg::mfic_cwr_t lane_cwr;

    assign lane_cwr.we_base  = cwr.we_base && ob == 2'(l);
    assign lane_cwr.we_slope = cwr.we_slope && ob == 2'(l);

    mfic_lane #(
      .BANDS (BANDS),
      .TAPS  (TAPS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .blend_i   (blend_q),
      .cwr_i     (lane_cwr),
      .wr_addr_i (wr_addr),
      .wr_data_i (cval),
      .rd_addr_i (coef_addr),
      .ctl_i     (ctl),
      .smp_i     (lane_smp),
      .res_o     (res[l]),
      .res_ok_o  (res_ok[l])
    );
  end

  mfic_merge #(
    .BANDS (BANDS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .res_i    (res),
    .tready_i (m_axis_tready),
    .tvalid_o (m_axis_tvalid),
    .tdata_o  (m_axis_tdata),
    .free_o   (out_free)
  );

endmodule

>>> design/mfic_checker.sv
// ----------------------------------------------------------------------------
// mfic_checker
// port-level checks of the mimo fir unit, bound to the top level
// ----------------------------------------------------------------------------
module mfic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // a push makes the unit busy
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == mfic_pkg::CMD_PUSH
    |=> !s_axis_tready)
    else $error("unit took an item while filtering");

  // other commands leave the input ready
  a_cmd_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != mfic_pkg::CMD_PUSH
    |=> s_axis_tready)
    else $error("non-push command stalled the input");

  // a new result only shows up at the end of a push
  a_out_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result item without a push in progress");

  // blend factor reads back what was written
  a_blend_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr == 3'd0
    |=> paddr != 3'd0 || prdata[15:0] == $past(pwdata[15:0]))
    else $error("blend factor readback mismatch");

endmodule

bind mimo_fir_interpolated_coeffs_unit mfic_checker u_mfic_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the interpolated-coefficient mimo fir unit
// ----------------------------------------------------------------------------
// Items go in on the s_axis stream and results are taken from m_axis. Both
// sides idle at random. A behavioral copy of the filter runs in the bench and
// predicts every output item. A short directed table comes first: it covers
// the sample and coefficient extremes, saturation, out-of-range coefficient
// addresses and history clear. Then come random phases under several blend
// factors, the two extremes among them; each phase writes coefficients at
// its own scale, so that not every output saturates.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BANDS          = 4;
  localparam int TAPS           = 65;
  localparam int GAP_MAX        = 17;
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_AFTER     = 150;   // long sink stall after this many results
  localparam int HOLD_CYCLES    = 1500;
  localparam int PHASES         = 4;
  localparam int RAND_PER_PHASE = 115;
  localparam int DIR_N          = 18;

  // one input item, split into its fields
  typedef struct packed {
    logic [mfic_pkg::CMD_W-1:0]                           cmd;
    logic [1:0]                                           ob;
    logic [1:0]                                           ib;
    logic [6:0]                                           tap;
    logic [15:0]                                          cval;
    logic [mfic_pkg::MAX_BANDS-1:0][mfic_pkg::SMP_W-1:0]  smp;
  } fir_item_t;

  // directed row: item plus an optional hand-typed result
  typedef struct packed {
    fir_item_t   item;
    logic        typed;
    logic [63:0] res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni   = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: coef_out_band, coef_in_band, coef_tap, coef_value,
  //        sample_0, sample_1, sample_2, sample_3, zero fill
  logic [95:0] s_tdata  = '0;
  // tuser: command
  logic [1:0]  s_tuser  = mfic_pkg::CMD_CLEAR;
  logic        m_axis_tvalid;
  logic        m_tready = 1'b0;
  // tdata: out_0, out_1, out_2, out_3
  logic [63:0] m_axis_tdata;

  mimo_fir_interpolated_coeffs_unit #(
    .BANDS(BANDS),
    .TAPS (TAPS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // filter state held by the bench
  shortint     hist_q  [BANDS][TAPS-1];   // [band][j] = sample j+1 steps back
  shortint     base_w  [BANDS][BANDS][TAPS];
  shortint     slope_w [BANDS][BANDS][TAPS];
  shortint     blend_q = 0;

  logic [63:0] band_out_q [$];            // expected output items, oldest first
  dir_row_t    dir_tab [DIR_N];

  int mismatches  = 0;
  int n_push      = 0;
  int n_coef      = 0;
  int n_clear     = 0;
  int n_results   = 0;
  int n_blend     = 0;
  int src_burst   = 0;
  int sink_burst  = 0;
  bit sink_held   = 1'b0;

  int          shift_plan [PHASES] = '{8, 7, 10, 6};
  logic [15:0] blend_plan [PHASES];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic log_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // idle count for one item, with runs of back-to-back items now and then
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      burst = $urandom_range(4, 24);
      return 0;
    end
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic fir_item_t mk_item(logic [1:0] cmd, logic [1:0] ob, logic [1:0] ib,
                                        logic [6:0] tap, logic [15:0] cval,
                                        logic [15:0] s0, logic [15:0] s1,
                                        logic [15:0] s2, logic [15:0] s3);
    fir_item_t it;
    it.cmd    = cmd;
    it.ob     = ob;
    it.ib     = ib;
    it.tap    = tap;
    it.cval   = cval;
    it.smp[0] = s0;
    it.smp[1] = s1;
    it.smp[2] = s2;
    it.smp[3] = s3;
    return it;
  endfunction

  function automatic logic [95:0] pack_item(fir_item_t it);
    return {5'b0, it.smp[3], it.smp[2], it.smp[1], it.smp[0],
            it.cval, it.tap, it.ib, it.ob};
  endfunction

  // sample with a bias toward the extremes and zero
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // every field random, the command picked afterwards
  function automatic fir_item_t rand_item(int shift);
    fir_item_t   it;
    logic [15:0] raw;
    int          pick;
    raw  = 16'($urandom);
    pick = $urandom_range(0, 99);
    it   = mk_item(mfic_pkg::CMD_PUSH, 2'($urandom), 2'($urandom), 7'($urandom),
                   16'($urandom),
                   rand_sample(), rand_sample(), rand_sample(), rand_sample());
    if (pick >= 95) begin
      it.cmd = mfic_pkg::CMD_CLEAR;
    end else if (pick >= 72) begin
      it.cmd  = $urandom_range(0, 1) ? mfic_pkg::CMD_BASE : mfic_pkg::CMD_SLOPE;
      it.tap  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
                                             : 7'($urandom_range(0, TAPS - 1));
      it.cval = $signed(raw) >>> $urandom_range(0, shift);
    end
    return it;
  endfunction

  // filter behavior: coefficient stores, history, blended weights
  task automatic model_step(input fir_item_t it, output bit has_out,
                            output logic [63:0] res);
    longint  acc;
    longint  w;
    longint  r;
    shortint s;
    has_out = 1'b0;
    res     = '0;
    case (it.cmd)
      mfic_pkg::CMD_BASE, mfic_pkg::CMD_SLOPE: begin
        // out-of-range addresses are dropped
        if (it.ob < BANDS && it.ib < BANDS && it.tap < TAPS) begin
          if (it.cmd == mfic_pkg::CMD_BASE) base_w[it.ob][it.ib][it.tap] = shortint'(it.cval);
          else slope_w[it.ob][it.ib][it.tap] = shortint'(it.cval);
        end
      end
      mfic_pkg::CMD_CLEAR: begin
        foreach (hist_q[p, j]) hist_q[p][j] = 0;
      end
      default: begin
        has_out = 1'b1;
        for (int b = 0; b < BANDS; b++) begin
          acc = 0;
          for (int p = 0; p < BANDS; p++) begin
            for (int k = 0; k < TAPS; k++) begin
              s = (k == 0) ? shortint'(it.smp[p]) : hist_q[p][k-1];
              // base + blend*slope, rounded half up to q2.14
              w = longint'(base_w[b][p][k]) +
                  ((longint'(blend_q) * longint'(slope_w[b][p][k]) + 8192) >>> 14);
              acc += w * longint'(s);
            end
          end
          r = (acc + 8192) >>> 14;
          if (r > 32767)  r = 32767;
          if (r < -32768) r = -32768;
          res[16*b +: 16] = r[15:0];
        end
        // age the history by one step
        for (int p = 0; p < BANDS; p++) begin
          for (int j = TAPS - 2; j > 0; j--) hist_q[p][j] = hist_q[p][j-1];
          hist_q[p][0] = shortint'(it.smp[p]);
        end
      end
    endcase
  endtask

  // offer one item, update the model once it is taken
  task automatic send_item(input fir_item_t it, input bit typed = 1'b0,
                           input logic [63:0] typed_res = '0);
    int          gap;
    bit          has_out;
    logic [63:0] res;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_item(it);
    s_tuser  <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    model_step(it, has_out, res);
    if (has_out) band_out_q.push_back(typed ? typed_res : res);
    case (it.cmd)
      mfic_pkg::CMD_PUSH:  n_push++;
      mfic_pkg::CMD_CLEAR: n_clear++;
      default:             n_coef++;
    endcase
  endtask

  // stop offering and wait for every expected output item
  task automatic drain_results(input int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (band_out_q.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // one register access: setup, then access until pready
  task automatic apb_xfer(input logic wr, input logic [31:0] wd, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {mfic_pkg::REG_BLEND, 2'b00};
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_blend(input logic [15:0] v);
    logic [31:0] rd;
    apb_xfer(1'b1, {{16{v[15]}}, v}, rd);
    blend_q = shortint'(v);
    n_blend++;
    apb_xfer(1'b0, '0, rd);
    if (rd[15:0] !== v) log_mismatch($sformatf("blend read back %h, wrote %h", rd[15:0], v));
  endtask

  // write every base and slope coefficient, scaled down by shift or all zero
  task automatic load_all_coefs(input int shift, input bit zero);
    fir_item_t   it;
    logic [15:0] raw;
    for (int ob = 0; ob < BANDS; ob++) begin
      for (int ib = 0; ib < BANDS; ib++) begin
        for (int k = 0; k < TAPS; k++) begin
          for (int kind = 0; kind < 2; kind++) begin
            raw = 16'($urandom);
            it  = rand_item(0);
            it.cmd  = kind ? mfic_pkg::CMD_SLOPE : mfic_pkg::CMD_BASE;
            it.ob   = 2'(ob);
            it.ib   = 2'(ib);
            it.tap  = 7'(k);
            it.cval = zero ? 16'h0000 : 16'($signed(raw) >>> shift);
            send_item(it);
          end
        end
      end
    end
  endtask

  // result side: random stalls, one long hold, field-by-field compare
  initial begin : result_sink
    int          gap;
    logic [63:0] want;
    forever begin
      if (n_results == HOLD_AFTER && !sink_held) begin
        sink_held = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = draw_gap(sink_burst);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (band_out_q.size() == 0) begin
        log_mismatch($sformatf("output item %h with nothing expected", m_axis_tdata));
      end else begin
        want = band_out_q.pop_front();
        for (int b = 0; b < BANDS; b++) begin
          if (m_axis_tdata[16*b +: 16] !== want[16*b +: 16])
            log_mismatch($sformatf("output %0d band %0d: got %h expected %h", n_results, b,
                                   m_axis_tdata[16*b +: 16], want[16*b +: 16]));
        end
      end
      n_results++;
    end
  end

  // main stimulus
  initial begin : stimulus
    logic [31:0] rd;

    // directed rows; coefficients are all zero when these start
    dir_tab[0]  = '{mk_item(mfic_pkg::CMD_PUSH, 0, 0, 0, 0,
                            16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1, 64'h0};
    dir_tab[1]  = '{mk_item(mfic_pkg::CMD_PUSH, 3, 3, 127, 16'hffff,
                            16'h7fff, 16'h8000, 16'h1234, 16'hffff), 1'b1, 64'h0};
    dir_tab[2]  = '{mk_item(mfic_pkg::CMD_BASE, 0, 0, 0, 16'h4000, 0, 0, 0, 0),
                    1'b0, 64'h0};
    dir_tab[3]  = '{mk_item(mfic_pkg::CMD_BASE, 3, 3, 64, 16'h8000, 0, 0, 0, 0),
                    1'b0, 64'h0};
    dir_tab[4]  = '{mk_item(mfic_pkg::CMD_BASE, 1, 0, 0, 16'h8000, 0, 0, 0, 0),
                    1'b0, 64'h0};
    // tap just past the end and the highest tap code: both dropped
    dir_tab[5]  = '{mk_item(mfic_pkg::CMD_BASE, 2, 2, 65, 16'h7fff, 0, 0, 0, 0),
                    1'b0, 64'h0};
    dir_tab[6]  = '{mk_item(mfic_pkg::CMD_SLOPE, 2, 1, 127, 16'h7fff, 0, 0, 0, 0),
                    1'b0, 64'h0};
    // unity and minus-two weights on band 0: exact, then saturated
    dir_tab[7]  = '{mk_item(mfic_pkg::CMD_PUSH, 0, 0, 0, 0, 16'h7fff, 0, 0, 0),
                    1'b1, {16'h0000, 16'h0000, 16'h8000, 16'h7fff}};
    dir_tab[8]  = '{mk_item(mfic_pkg::CMD_PUSH, 0, 0, 0, 0, 16'h8000, 0, 0, 0),
                    1'b1, {16'h0000, 16'h0000, 16'h7fff, 16'h8000}};
    dir_tab[9]  = '{mk_item(mfic_pkg::CMD_PUSH, 0, 0, 0, 0, 16'h0001, 0, 0, 0),
                    1'b1, {16'h0000, 16'h0000, 16'hfffe, 16'h0001}};
    dir_tab[10] = '{mk_item(mfic_pkg::CMD_CLEAR, 1, 2, 3, 16'h5555, 16'h7fff, 0, 0, 0),
                    1'b0, 64'h0};
    dir_tab[11] = '{mk_item(mfic_pkg::CMD_PUSH, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 64'h0};
    dir_tab[12] = '{mk_item(mfic_pkg::CMD_SLOPE, 0, 1, 0, 16'h7fff, 0, 0, 0, 0),
                    1'b0, 64'h0};
    dir_tab[13] = '{mk_item(mfic_pkg::CMD_BASE, 2, 3, 1, 16'h2000, 0, 0, 0, 0),
                    1'b0, 64'h0};
    dir_tab[14] = '{mk_item(mfic_pkg::CMD_BASE, 3, 0, 0, 16'h0001, 0, 0, 0, 0),
                    1'b0, 64'h0};
    // half-lsb products: one rounds up, the other down to zero
    dir_tab[15] = '{mk_item(mfic_pkg::CMD_PUSH, 0, 0, 0, 0,
                            16'h2000, 16'h7fff, 0, 16'h4000), 1'b0, 64'h0};
    dir_tab[16] = '{mk_item(mfic_pkg::CMD_PUSH, 0, 0, 0, 0, 16'he000, 0, 0, 16'h1234),
                    1'b0, 64'h0};
    dir_tab[17] = '{mk_item(mfic_pkg::CMD_PUSH, 0, 0, 0, 0,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0, 64'h0};

    blend_plan[0] = 16'h7fff;
    blend_plan[1] = 16'h8000;
    blend_plan[2] = 16'($urandom);
    blend_plan[3] = 16'he000;
    foreach (hist_q[p, j]) hist_q[p][j] = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // blend factor comes out of reset as zero
    apb_xfer(1'b0, '0, rd);
    if (rd[15:0] !== 16'h0000) log_mismatch($sformatf("blend after reset %h", rd[15:0]));

    load_all_coefs(0, 1'b1);
    for (int i = 0; i < DIR_N; i++) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
    drain_results(SETTLE_CYCLES);

    // random phases, each under its own blend factor and coefficient scale
    for (int ph = 0; ph < PHASES; ph++) begin
      write_blend(blend_plan[ph]);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        send_item(rand_item(shift_plan[ph]));
        // sender pause until the pipeline is empty
        if (ph == 1 && i == RAND_PER_PHASE / 2) drain_results(0);
      end
      drain_results(SETTLE_CYCLES);
    end

    $display("covered %0d pushes, %0d coefficient writes, %0d history clears",
             n_push, n_coef, n_clear);
    $display("%0d output items checked under %0d blend factor settings", n_results, n_blend + 1);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #15ms;
    $display("timeout: %0d output items still outstanding", band_out_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> mimo_fir_interpolated_coeffs_unit.f
design/mfic_pkg.sv
design/mfic_lane.sv
design/mfic_seq.sv
design/mfic_merge.sv
design/mimo_fir_interpolated_coeffs_unit.sv
design/mfic_checker.sv
verif/tb.sv
